>>> hw/rtl/sfvg_pkg.sv
`timescale 1ns / 1ps
package sfvg_pkg;
    localparam int CoordFracBits = 8;
    localparam int CoefFracBits  = 14;
    localparam int NGlyph        = 101;
    localparam int MaxStk        = 14;
    localparam int GlyphW        = 7;
    localparam int StkW          = 4;

    localparam logic [2:0] REG_GRID_STEP = 3'd0;
    localparam logic [2:0] REG_M_XX      = 3'd1;
    localparam logic [2:0] REG_M_XY      = 3'd2;
    localparam logic [2:0] REG_M_YX      = 3'd3;
    localparam logic [2:0] REG_M_YY      = 3'd4;
    localparam logic [2:0] REG_ORIGIN_X  = 3'd5;
    localparam logic [2:0] REG_ORIGIN_Y  = 3'd6;

    typedef struct packed {
        logic [GlyphW-1:0] glyph;
        logic              end_str;
    } t_cmd;

    typedef struct packed {
        logic [19:0]        grid_step;
        logic signed [15:0] m_xx;
        logic signed [15:0] m_xy;
        logic signed [15:0] m_yx;
        logic signed [15:0] m_yy;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
    } t_cfg;

    typedef struct packed {
        logic        pen_down;
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic        last_of_char;
    } t_pt;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ORIGIN,
        ST_STROKE,
        ST_ADV
    } t_bstate;

    // Stroke entry: [6:0] 11*col+row, [7] draw, [8] mirror y, [9] valid.
    function automatic logic [9:0] sm(input int c, input int r);
        return 10'h200 | 10'(11 * c + r);
    endfunction
    function automatic logic [9:0] sl(input int c, input int r);
        return 10'h280 | 10'(11 * c + r);
    endfunction
    function automatic logic [9:0] sln(input int c, input int r);
        return 10'h380 | 10'(11 * c + r);
    endfunction
    function automatic logic [9:0] smn(input int c, input int r);
        return 10'h300 | 10'(11 * c + r);
    endfunction

    typedef logic [9:0] t_row [MaxStk];

    function automatic t_row glyph_row(input logic [GlyphW-1:0] g);
        t_row r;
        for (int i = 0; i < MaxStk; i++) r[i] = 10'h000;
        case (g)
            7'd0: begin r[0]=sm(0,5);r[1]=sl(8,5);r[2]=sm(4,8);r[3]=sl(4,2); end
            7'd1: begin r[0]=sm(0,2);r[1]=sl(8,8);r[2]=sm(0,8);r[3]=sl(8,2); end
            7'd2: begin r[0]=sm(0,2);r[1]=sl(4,8);r[2]=sl(8,2);r[3]=sl(0,2); end
            7'd3: begin r[0]=sm(0,2);r[1]=sl(0,8);r[2]=sl(8,8);r[3]=sl(8,2);r[4]=sl(0,2); end
            7'd4: begin r[0]=sm(0,2);r[1]=sl(8,8);r[2]=sl(0,8);r[3]=sl(8,2);r[4]=sl(0,2); end
            7'd5: ;
            7'd6: r = '{sm(3,0),sl(5,2),sl(5,0),sl(3,2),sl(3,0),sm(4,4),sl(3,10),sl(5,10),
                        sl(4,4),sl(4,10),0,0,0,0};
            7'd7: r = '{sm(1,10),sl(3,10),sl(2,7),sl(1,10),sm(5,10),sl(7,10),sl(6,7),
                        sl(5,10),0,0,0,0,0,0};
            7'd8: r = '{sm(1,0),sl(3,9),sm(6,9),sl(4,0),sm(6,3),sl(0,3),sm(1,6),sl(7,6),
                        0,0,0,0,0,0};
            7'd9: r = '{sm(1,2),sl(1,1),sl(7,1),sl(7,5),sl(1,5),sl(1,9),sl(7,9),sl(7,8),
                        sm(4,10),sl(4,0),0,0,0,0};
            7'd10: r = '{sm(3,10),sl(3,7),sl(0,7),sl(0,10),sl(8,10),sl(0,0),sm(8,0),
                         sl(5,0),sl(5,3),sl(8,3),sl(8,0),0,0,0};
            7'd11: r = '{sm(7,3),sl(4,0),sl(1,0),sl(0,3),sl(5,8),sl(4,10),sl(3,10),
                         sl(1,8),sl(8,0),0,0,0,0,0};
            7'd12: r = '{sm(4,6),sl(5,10),sl(6,10),sl(4,6),0,0,0,0,0,0,0,0,0,0};
            7'd13: r = '{sm(5,0),sl(3,1),sl(2,4),sl(2,6),sl(3,9),sl(5,10),0,0,0,0,0,0,0,0};
            7'd14: r = '{sm(3,0),sl(5,1),sl(6,4),sl(6,6),sl(5,9),sl(3,10),0,0,0,0,0,0,0,0};
            7'd15: r = '{sm(4,2),sl(4,8),sm(6,7),sl(2,3),sm(6,3),sl(2,7),sm(1,5),sl(7,5),
                         0,0,0,0,0,0};
            7'd16: r = '{sm(1,5),sl(7,5),sm(4,8),sl(4,2),0,0,0,0,0,0,0,0,0,0};
            7'd17: r = '{sm(5,0),sl(3,2),sl(3,0),sl(5,2),sl(5,0),sln(2,2),sl(4,0),
                         0,0,0,0,0,0,0};
            7'd18: r = '{sm(1,5),sl(7,5),0,0,0,0,0,0,0,0,0,0,0,0};
            7'd19: r = '{sm(5,0),sl(3,2),sl(3,0),sl(5,2),sl(5,0),0,0,0,0,0,0,0,0,0};
            7'd20: r = '{sl(8,10),0,0,0,0,0,0,0,0,0,0,0,0,0};
            7'd21: r = '{sm(8,10),sl(0,0),sl(0,10),sl(8,10),sl(8,0),sl(0,0),0,0,0,0,0,0,0,0};
            7'd22: r = '{sm(4,0),sl(4,10),sl(2,8),0,0,0,0,0,0,0,0,0,0,0};
            7'd23: r = '{sm(0,6),sl(0,8),sl(3,10),sl(5,10),sl(8,8),sl(8,7),sl(0,2),sl(0,0),
                         sl(8,0),0,0,0,0,0};
            7'd24: r = '{sm(0,10),sl(8,10),sl(8,5),sl(0,5),sl(8,5),sl(8,0),sl(0,0),
                         0,0,0,0,0,0,0};
            7'd25: r = '{sm(0,10),sl(0,5),sl(8,5),sm(8,10),sl(8,0),0,0,0,0,0,0,0,0,0};
            7'd26: r = '{sm(8,10),sl(0,10),sl(0,5),sl(8,5),sl(8,0),sl(0,0),0,0,0,0,0,0,0,0};
            7'd27: r = '{sm(0,10),sl(0,0),sl(8,0),sl(8,5),sl(0,5),0,0,0,0,0,0,0,0,0};
            7'd28: r = '{sm(0,10),sl(8,10),sl(6,0),0,0,0,0,0,0,0,0,0,0,0};
            7'd29: r = '{sm(0,5),sl(0,0),sl(8,0),sl(8,5),sl(0,5),sl(0,10),sl(8,10),sl(8,5),
                         0,0,0,0,0,0};
            7'd30: r = '{sm(8,5),sl(0,5),sl(0,10),sl(8,10),sl(8,0),0,0,0,0,0,0,0,0,0};
            7'd31: r = '{sm(5,6),sl(3,8),sl(3,6),sl(5,8),sl(5,6),sm(5,0),sl(3,2),sl(3,0),
                         sl(5,2),sl(5,0),0,0,0,0};
            7'd32: r = '{sm(5,6),sl(3,8),sl(3,6),sl(5,8),sl(5,6),sm(5,0),sl(3,2),sl(3,0),
                         sl(5,2),sl(5,0),sln(2,2),sl(4,0),0,0};
            7'd33: r = '{sm(8,8),sl(0,5),sl(8,2),0,0,0,0,0,0,0,0,0,0,0};
            7'd34: r = '{sm(0,7),sl(8,7),sm(0,3),sl(8,3),0,0,0,0,0,0,0,0,0,0};
            7'd35: r = '{sm(0,8),sl(8,5),sl(0,2),0,0,0,0,0,0,0,0,0,0,0};
            7'd36: r = '{sm(3,0),sl(5,2),sl(5,0),sl(3,2),sl(3,0),sm(1,7),sl(1,9),sl(3,10),
                         sl(5,10),sl(7,9),sl(7,7),sl(4,5),sl(4,3),0};
            7'd37: r = '{sm(0,8),sl(2,10),sl(6,10),sl(8,8),sl(8,2),sl(6,0),sl(2,0),sl(1,1),
                         sl(1,4),sl(2,5),sl(4,5),sl(5,4),sl(5,0),0};
            7'd38: r = '{sl(0,8),sl(2,10),sl(6,10),sl(8,8),sl(8,0),sm(0,5),sl(8,5),
                         0,0,0,0,0,0,0};
            7'd39: r = '{sl(0,10),sl(5,10),sl(8,9),sl(8,6),sl(5,5),sl(0,5),sl(5,5),sl(8,4),
                         sl(8,1),sl(5,0),sl(0,0),0,0,0};
            7'd40: r = '{sm(8,2),sl(6,0),sl(2,0),sl(0,2),sl(0,8),sl(2,10),sl(6,10),sl(8,8),
                         0,0,0,0,0,0};
            7'd41: r = '{sl(0,10),sl(5,10),sl(8,8),sl(8,2),sl(5,0),sl(0,0),0,0,0,0,0,0,0,0};
            7'd42: r = '{sm(8,0),sl(0,0),sl(0,10),sl(8,10),sm(0,5),sl(5,5),0,0,0,0,0,0,0,0};
            7'd43: r = '{sl(0,10),sl(8,10),sm(0,5),sl(5,5),0,0,0,0,0,0,0,0,0,0};
            7'd44: r = '{sm(5,5),sl(8,5),sl(8,2),sl(6,0),sl(2,0),sl(0,2),sl(0,8),sl(2,10),
                         sl(6,10),sl(8,8),0,0,0,0};
            7'd45: r = '{sl(0,10),sm(8,10),sl(8,0),sm(0,6),sl(8,6),0,0,0,0,0,0,0,0,0};
            7'd46: r = '{sm(4,0),sl(6,0),sm(5,0),sl(5,10),sl(4,10),sl(6,10),0,0,0,0,0,0,0,0};
            7'd47: r = '{sm(0,2),sl(2,0),sl(5,0),sl(7,2),sl(7,10),sl(6,10),sl(8,10),
                         0,0,0,0,0,0,0};
            7'd48: r = '{sl(0,10),sm(0,5),sl(8,10),sm(3,7),sl(8,0),0,0,0,0,0,0,0,0,0};
            7'd49: r = '{sm(8,0),sl(0,0),sl(0,10),0,0,0,0,0,0,0,0,0,0,0};
            7'd50: r = '{sl(0,10),sl(4,5),sl(8,10),sl(8,10),sl(8,0),0,0,0,0,0,0,0,0,0};
            7'd51: r = '{sl(0,10),sl(8,0),sl(8,10),0,0,0,0,0,0,0,0,0,0,0};
            7'd52: r = '{sm(0,2),sl(0,8),sl(2,10),sl(6,10),sl(8,8),sl(8,2),sl(6,0),sl(2,0),
                         sl(0,2),0,0,0,0,0};
            7'd53: r = '{sl(0,10),sl(6,10),sl(8,9),sl(8,6),sl(6,5),sl(0,5),0,0,0,0,0,0,0,0};
            7'd54: r = '{sm(0,2),sl(0,8),sl(2,10),sl(6,10),sl(8,8),sl(8,2),sl(6,0),sl(2,0),
                         sl(0,2),sm(5,3),sl(8,0),0,0,0};
            7'd55: r = '{sl(0,10),sl(6,10),sl(8,8),sl(8,6),sl(6,5),sl(0,5),sm(5,5),sl(8,0),
                         0,0,0,0,0,0};
            7'd56: r = '{sm(0,1),sl(1,0),sl(6,0),sl(8,2),sl(8,4),sl(6,6),sl(2,6),sl(0,7),
                         sl(0,9),sl(1,10),sl(7,10),sl(8,9),0,0};
            7'd57: r = '{sm(4,0),sl(4,10),sm(0,10),sl(8,10),0,0,0,0,0,0,0,0,0,0};
            7'd58: r = '{sm(0,10),sl(0,2),sl(2,0),sl(6,0),sl(8,2),sl(8,10),0,0,0,0,0,0,0,0};
            7'd59: r = '{sm(0,10),sl(4,0),sl(8,10),0,0,0,0,0,0,0,0,0,0,0};
            7'd60: r = '{sm(0,10),sl(1,0),sl(4,4),sl(7,0),sl(8,10),0,0,0,0,0,0,0,0,0};
            7'd61: r = '{sl(8,10),sm(0,10),sl(8,0),0,0,0,0,0,0,0,0,0,0,0};
            7'd62: r = '{sm(0,10),sl(4,4),sl(8,10),sm(4,4),sl(4,0),0,0,0,0,0,0,0,0,0};
            7'd63: r = '{sm(0,10),sl(8,10),sl(0,0),sl(8,0),0,0,0,0,0,0,0,0,0,0};
            7'd64: r = '{sm(6,0),sl(4,0),sl(4,10),sl(6,10),0,0,0,0,0,0,0,0,0,0};
            7'd65: r = '{sm(0,10),sl(8,0),0,0,0,0,0,0,0,0,0,0,0,0};
            7'd66: r = '{sm(2,0),sl(4,0),sl(4,10),sl(2,10),0,0,0,0,0,0,0,0,0,0};
            7'd67: r = '{sm(4,0),sl(4,10),sm(2,8),sl(4,10),sl(6,8),0,0,0,0,0,0,0,0,0};
            7'd68: r = '{smn(0,1),sln(11,1),0,0,0,0,0,0,0,0,0,0,0,0};
            7'd69: r = '{sm(3,10),sl(5,6),sl(4,10),sl(3,10),0,0,0,0,0,0,0,0,0,0};
            7'd70: r = '{sm(0,5),sl(1,6),sl(6,6),sl(7,5),sl(7,1),sl(8,0),sm(7,1),sl(6,0),
                         sl(1,0),sl(0,1),sl(0,2),sl(1,3),sl(6,3),sl(7,2)};
            7'd71: r = '{sl(0,10),sm(8,3),sl(7,5),sl(4,6),sl(1,5),sl(0,3),sl(1,1),sl(4,0),
                         sl(7,1),sl(8,3),0,0,0,0};
            7'd72: r = '{sm(8,5),sl(7,6),sl(2,6),sl(0,4),sl(0,4),sl(0,2),sl(2,0),sl(7,0),
                         sl(8,1),0,0,0,0,0};
            7'd73: r = '{sm(8,0),sl(8,10),sm(8,3),sl(7,5),sl(4,6),sl(1,5),sl(0,3),sl(1,1),
                         sl(4,0),sl(7,1),sl(8,3),0,0,0};
            7'd74: r = '{sm(0,4),sl(1,3),sl(7,3),sl(8,4),sl(8,5),sl(7,6),sl(1,6),sl(0,5),
                         sl(0,1),sl(1,0),sl(7,0),sl(8,1),0,0};
            7'd75: r = '{sm(2,0),sl(2,9),sl(3,10),sl(5,10),sl(6,9),sm(1,5),sl(4,5),
                         0,0,0,0,0,0,0};
            7'd76: r = '{sm(8,6),sm(8,3),sl(7,5),sl(4,6),sl(1,5),sl(0,3),sl(1,1),sl(4,0),
                         sl(7,1),sl(8,3),sln(8,2),sln(7,3),sln(1,3),sln(0,2)};
            7'd77: r = '{sl(0,10),sm(0,4),sl(2,6),sl(6,6),sl(8,4),sl(8,0),0,0,0,0,0,0,0,0};
            7'd78: r = '{sm(4,0),sl(4,6),sl(3,6),sm(4,9),sl(4,8),sm(3,0),sl(5,0),
                         0,0,0,0,0,0,0};
            7'd79: r = '{sm(5,6),sl(6,6),sln(6,2),sln(5,3),sln(3,3),sln(2,2),0,0,0,0,0,0,0,0};
            7'd80: r = '{sl(2,0),sl(2,10),sl(0,10),sm(2,4),sl(4,4),sl(8,6),sm(4,4),sl(8,0),
                         0,0,0,0,0,0};
            7'd81: r = '{sm(3,10),sl(4,10),sl(4,2),sl(5,0),0,0,0,0,0,0,0,0,0,0};
            7'd82: r = '{sl(0,6),sm(0,5),sl(1,6),sl(3,6),sl(4,5),sl(4,0),sm(4,5),sl(5,6),
                         sl(7,6),sl(8,5),sl(8,0),0,0,0};
            7'd83: r = '{sl(0,6),sm(0,4),sl(2,6),sl(6,6),sl(8,4),sl(8,0),0,0,0,0,0,0,0,0};
            7'd84: r = '{sm(8,3),sl(7,5),sl(4,6),sl(1,5),sl(0,3),sl(1,1),sl(4,0),sl(7,1),
                         sl(8,3),0,0,0,0,0};
            7'd85: r = '{sm(0,6),sln(0,3),sm(8,3),sl(7,5),sl(4,6),sl(1,5),sl(0,3),sl(1,1),
                         sl(4,0),sl(7,1),sl(8,3),0,0,0};
            7'd86: r = '{sm(8,6),sm(8,3),sl(7,5),sl(4,6),sl(1,5),sl(0,3),sl(1,1),sl(4,0),
                         sl(7,1),sl(8,3),sln(8,3),sln(9,3),0,0};
            7'd87: r = '{sl(1,0),sl(1,6),sl(0,6),sm(1,4),sl(3,6),sl(6,6),sl(8,4),
                         0,0,0,0,0,0,0};
            7'd88: r = '{sm(0,1),sl(1,0),sl(7,0),sl(8,1),sl(7,2),sl(1,4),sl(0,5),sl(1,6),
                         sl(7,6),sl(8,5),0,0,0,0};
            7'd89: r = '{sm(7,1),sl(6,0),sl(4,0),sl(3,1),sl(3,10),sl(2,10),sm(1,5),sl(5,5),
                         0,0,0,0,0,0};
            7'd90: r = '{sm(0,6),sl(1,6),sl(1,1),sl(2,0),sl(6,0),sl(7,1),sl(7,6),sm(7,1),
                         sl(8,0),0,0,0,0,0};
            7'd91: r = '{sm(0,6),sl(4,0),sl(8,6),0,0,0,0,0,0,0,0,0,0,0};
            7'd92: r = '{sm(0,6),sl(0,5),sl(2,0),sl(4,5),sl(6,0),sl(8,5),sl(8,6),
                         0,0,0,0,0,0,0};
            7'd93: r = '{sl(8,6),sm(0,6),sl(8,0),0,0,0,0,0,0,0,0,0,0,0};
            7'd94: r = '{sm(0,6),sl(0,1),sl(1,0),sl(7,0),sl(8,1),sm(8,6),sln(8,2),sln(7,3),
                         sln(1,3),sln(0,2),0,0,0,0};
            7'd95: r = '{sm(0,6),sl(8,6),sl(0,0),sl(8,0),0,0,0,0,0,0,0,0,0,0};
            7'd96: r = '{sm(6,10),sl(5,10),sl(4,9),sl(4,6),sl(3,5),sl(4,4),sl(4,1),sl(5,0),
                         sl(6,0),0,0,0,0,0};
            7'd97: r = '{sm(4,4),sl(4,0),sl(5,0),sl(5,4),sl(4,4),sm(4,6),sl(4,10),sl(5,10),
                         sl(5,6),sl(4,6),0,0,0,0};
            7'd98: r = '{sm(2,0),sl(3,0),sl(4,1),sl(4,4),sl(5,5),sl(4,6),sl(4,9),sl(3,10),
                         sl(2,10),0,0,0,0,0};
            7'd99: r = '{sm(0,5),sl(1,6),sl(3,6),sl(5,4),sl(7,4),sl(8,5),0,0,0,0,0,0,0,0};
            7'd100: r = '{sm(0,2),sl(0,8),sl(8,8),sl(8,2),sl(0,2),0,0,0,0,0,0,0,0,0};
            default: ;
        endcase
        return r;
    endfunction

    // Token 11*col+row split by a small table.
    function automatic logic [7:0] tok_split(input logic [6:0] tok);
        logic [3:0] c;
        logic [3:0] rr;
        c  = 4'd0;
        rr = 4'd0;
        for (int k = 0; k < 12; k++) begin
            if (int'(tok) >= 11 * k && int'(tok) < 11 * k + 11) begin
                c  = 4'(k);
                rr = 4'(int'(tok) - 11 * k);
            end
        end
        return {c, rr};
    endfunction
endpackage

>>> hw/rtl/sfvg_if.sv
`timescale 1ns / 1ps
interface sfvg_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    modport source (output valid, output char_code, input ready);
    modport sink (input valid, input char_code, output ready);
endinterface

interface sfvg_pt_if;
    logic        valid;
    logic        ready;
    logic        pen_down;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic        last_of_char;
    modport source (output valid, output pen_down, output out_x, output out_y,
                    output last_of_char, input ready);
    modport sink (input valid, input pen_down, input out_x, input out_y,
                  input last_of_char, output ready);
endinterface

interface sfvg_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/stroke_font_vector_generator.sv
`timescale 1ns / 1ps
// channel   dir  payload
// i_char    in   char_code[7:0]
// o_pt      out  pen_down, out_x[31:0], out_y[31:0], last_of_char
// i_cfg     in   index[2:0], data[31:0]
// A character with n strokes steps the sequencer through pop, origin,
// n strokes (at most 14) and offset advance. Points leave a four-stage
// multiply pipeline. Reset (synchronous, active low) loads the register
// defaults and clears the offset. A stalled output freezes the whole
// point pipeline; the front queue keeps taking characters until it
// holds two.
module stroke_font_vector_generator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sfvg_char_if.sink i_char,
    sfvg_pt_if.source o_pt,
    sfvg_cfg_if.sink  i_cfg
);
    import sfvg_pkg::*;
    t_cfg r_cfg;
    t_cmd push_cmd, q_cmd;
    logic push, full, pop, empty;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_step <= 20'd256;
            r_cfg.m_xx      <= 16'sd16384;
            r_cfg.m_xy      <= '0;
            r_cfg.m_yx      <= '0;
            r_cfg.m_yy      <= 16'sd16384;
            r_cfg.origin_x  <= '0;
            r_cfg.origin_y  <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_GRID_STEP: r_cfg.grid_step <= i_cfg.data[19:0];
                REG_M_XX:      r_cfg.m_xx      <= i_cfg.data[15:0];
                REG_M_XY:      r_cfg.m_xy      <= i_cfg.data[15:0];
                REG_M_YX:      r_cfg.m_yx      <= i_cfg.data[15:0];
                REG_M_YY:      r_cfg.m_yy      <= i_cfg.data[15:0];
                REG_ORIGIN_X:  r_cfg.origin_x  <= i_cfg.data;
                REG_ORIGIN_Y:  r_cfg.origin_y  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    sfvg_front u_front (
        .i_char, .o_push(push), .o_cmd(push_cmd), .i_full(full)
    );

    sfvg_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_cmd(push_cmd), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_cmd(q_cmd)
    );

    sfvg_back u_back (
        .i_clk, .i_rst_n, .i_cfg(r_cfg), .i_empty(empty), .i_cmd(q_cmd),
        .o_pop(pop), .o_pt
    );
endmodule

>>> hw/rtl/sfvg_front.sv
`timescale 1ns / 1ps
module sfvg_front (
    sfvg_char_if.sink           i_char,
    output logic                o_push,
    output sfvg_pkg::t_cmd      o_cmd,
    input  logic                i_full
);
    import sfvg_pkg::*;
    logic [6:0] c;

    assign i_char.ready = !i_full;
    assign o_push       = i_char.valid && !i_full;
    assign c            = i_char.char_code[6:0];

    always_comb begin
        o_cmd.end_str = (i_char.char_code == 8'd0);
        if (c >= 7'd1 && c <= 7'd5) begin
            o_cmd.glyph = c - 7'd1;
        end else if (c >= 7'd32) begin
            o_cmd.glyph = c - 7'd27;
        end else begin
            o_cmd.glyph = 7'd36;
        end
    end
endmodule

>>> hw/rtl/sfvg_queue.sv
`timescale 1ns / 1ps
module sfvg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sfvg_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output sfvg_pkg::t_cmd o_cmd
);
    import sfvg_pkg::*;
    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end
endmodule

>>> hw/rtl/sfvg_back.sv
`timescale 1ns / 1ps
module sfvg_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sfvg_pkg::t_cfg i_cfg,
    input  logic           i_empty,
    input  sfvg_pkg::t_cmd i_cmd,
    output logic           o_pop,
    sfvg_pt_if.source      o_pt
);
    import sfvg_pkg::*;

    t_bstate    r_st, n_st;
    t_row       r_row;
    logic [StkW-1:0]   r_idx, n_idx;
    logic [31:0] r_off;
    // stage 1: local point
    logic        r1_v, n1_v;
    logic        r1_pen, r1_last, r1_neg;
    logic [3:0]  r1_col, r1_row;
    // stage 2: products col/row * step
    logic        r2_v;
    logic        r2_pen, r2_last;
    logic signed [33:0] r2_lx;
    logic signed [33:0] r2_ly;
    // stage 3: transform products
    logic        r3_v;
    logic        r3_pen, r3_last;
    logic signed [49:0] r3_pxx, r3_pxy, r3_pyx, r3_pyy;
    // stage 4: output register
    logic        r4_v;
    t_pt         r4_pt;
    logic        stall;
    logic [9:0]  ent;
    logic        nxt_ok;
    logic [7:0]  cr;
    logic [24:0] colp, rowp;
    logic signed [51:0] sx, sy;
    logic signed [51:0] tx, ty;
    logic [33:0] adv;

    // pipeline moves only when the output slot is free
    assign stall   = r4_v && !o_pt.ready;
    assign ent     = r_row[r_idx];
    assign nxt_ok  = (r_idx != StkW'(MaxStk - 1)) && r_row[r_idx + 1'b1][9];
    assign cr      = tok_split(ent[6:0]);

    always_comb begin
        n_st  = r_st;
        n_idx = r_idx;
        n1_v  = 1'b0;
        o_pop = 1'b0;
        if (!stall) begin
            case (r_st)
                ST_IDLE: begin
                    if (!i_empty) begin
                        o_pop = 1'b1;
                        if (!i_cmd.end_str) n_st = ST_ORIGIN;
                    end
                end
                ST_ORIGIN: begin
                    n1_v  = 1'b1;
                    n_idx = '0;
                    n_st  = r_row[0][9] ? ST_STROKE : ST_ADV;
                end
                ST_STROKE: begin
                    n1_v  = 1'b1;
                    n_idx = r_idx + 1'b1;
                    if (!nxt_ok) n_st = ST_ADV;
                end
                ST_ADV: n_st = ST_IDLE;
                default: n_st = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_IDLE;
            r_off <= '0;
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
        end else begin
            r_st <= n_st;
            if (!stall) begin
                r1_v <= n1_v;
                r2_v <= r1_v;
                r3_v <= r2_v;
                r4_v <= r3_v;
            end
            if (o_pop && i_cmd.end_str) r_off <= '0;
            if (!stall && r_st == ST_ADV) begin
                r_off <= adv[33:32] != 2'b00 ? 32'hFFFF_FFFF : adv[31:0];
            end
        end
    end

    assign adv = {2'b00, r_off} + 34'(i_cfg.grid_step) * 34'd10;

    assign colp = 25'(r1_col) * 25'(i_cfg.grid_step);
    assign rowp = 25'(r1_row) * 25'(i_cfg.grid_step);
    assign sx = 52'(r3_pxx) + 52'(r3_pxy) + 52'(1 << (CoefFracBits - 1));
    assign sy = 52'(r3_pyx) + 52'(r3_pyy) + 52'(1 << (CoefFracBits - 1));
    assign tx = (sx >>> CoefFracBits) + 52'(i_cfg.origin_x);
    assign ty = (sy >>> CoefFracBits) + 52'(i_cfg.origin_y);

    function automatic logic [31:0] sat(input logic signed [51:0] v);
        if (v > 52'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -52'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            if (o_pop) begin
                r_row   <= glyph_row(i_cmd.glyph);
            end
            r_idx   <= n_idx;
            r1_pen  <= (r_st == ST_STROKE) && ent[7];
            r1_neg  <= (r_st == ST_STROKE) && ent[8];
            r1_col  <= (r_st == ST_STROKE) ? cr[7:4] : 4'd0;
            r1_row  <= (r_st == ST_STROKE) ? cr[3:0] : 4'd0;
            r1_last <= (r_st == ST_ORIGIN) ? !r_row[0][9] : !nxt_ok;
            r2_pen  <= r1_pen;
            r2_last <= r1_last;
            r2_lx   <= 34'(colp) + 34'(r_off);
            r2_ly   <= r1_neg ? -34'(rowp) : 34'(rowp);
            r3_pen  <= r2_pen;
            r3_last <= r2_last;
            r3_pxx  <= r2_lx * i_cfg.m_xx;
            r3_pxy  <= r2_ly * i_cfg.m_xy;
            r3_pyx  <= r2_lx * i_cfg.m_yx;
            r3_pyy  <= r2_ly * i_cfg.m_yy;
            r4_pt.pen_down     <= r3_pen;
            r4_pt.last_of_char <= r3_last;
            r4_pt.out_x        <= sat(tx);
            r4_pt.out_y        <= sat(ty);
        end
    end

    assign o_pt.valid        = r4_v;
    assign o_pt.pen_down     = r4_pt.pen_down;
    assign o_pt.out_x        = r4_pt.out_x;
    assign o_pt.out_y        = r4_pt.out_y;
    assign o_pt.last_of_char = r4_pt.last_of_char;
endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
module tb;
    import sfvg_pkg::*;

    localparam int LimitCycles = 600000;
    localparam int HoldCycles  = 400;

    logic i_clk;
    logic i_rst_n;

    sfvg_char_if ch ();
    sfvg_pt_if   pt ();
    sfvg_cfg_if  cfg ();

    stroke_font_vector_generator dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_char (ch),
        .o_pt   (pt),
        .i_cfg  (cfg)
    );

    // Strokes per glyph, three characters each: kind, col, row (hex).
    // m move, l draw, M move mirrored, L draw mirrored.
    string glyph_strokes [NGlyph] = '{
        "m05l85m48l42", "m02l88m08l82", "m02l48l82l02", "m02l08l88l82l02",
        "m02l88l08l82l02", "",
        "m30l52l50l32l30m44l3al5al44l4a", "m1al3al27l1am5al7al67l5a",
        "m10l39m69l40m63l03m16l76", "m12l11l71l75l15l19l79l78m4al40",
        "m3al37l07l0al8al00m80l50l53l83l80", "m73l40l10l03l58l4al3al18l80",
        "m46l5al6al46", "m50l31l24l26l39l5a", "m30l51l64l66l59l3a",
        "m42l48m67l23m63l27m15l75", "m15l75m48l42", "m50l32l30l52l50L22l40",
        "m15l75", "m50l32l30l52l50", "l8a", "m8al00l0al8al80l00", "m40l4al28",
        "m06l08l3al5al88l87l02l00l80", "m0al8al85l05l85l80l00", "m0al05l85m8al80",
        "m8al0al05l85l80l00", "m0al00l80l85l05", "m0al8al60",
        "m05l00l80l85l05l0al8al85", "m85l05l0al8al80",
        "m56l38l36l58l56m50l32l30l52l50", "m56l38l36l58l56m50l32l30l52l50L22l40",
        "m88l05l82", "m07l87m03l83", "m08l85l02",
        "m30l52l50l32l30m17l19l3al5al79l77l45l43",
        "m08l2al6al88l82l60l20l11l14l25l45l54l50", "l08l2al6al88l80m05l85",
        "l0al5al89l86l55l05l55l84l81l50l00", "m82l60l20l02l08l2al6al88",
        "l0al5al88l82l50l00", "m80l00l0al8am05l55", "l0al8am05l55",
        "m55l85l82l60l20l02l08l2al6al88", "l0am8al80m06l86", "m40l60m50l5al4al6a",
        "m02l20l50l72l7al6al8a", "l0am05l8am37l80", "m80l00l0a", "l0al45l8al8al80",
        "l0al80l8a", "m02l08l2al6al88l82l60l20l02", "l0al6al89l86l65l05",
        "m02l08l2al6al88l82l60l20l02m53l80", "l0al6al88l86l65l05m55l80",
        "m01l10l60l82l84l66l26l07l09l1al7al89", "m40l4am0al8a", "m0al02l20l60l82l8a",
        "m0al40l8a", "m0al10l44l70l8a", "l8am0al80", "m0al44l8am44l40", "m0al8al00l80",
        "m60l40l4al6a", "m0al80", "m20l40l4al2a", "m40l4am28l4al68", "M01Lb1",
        "m3al56l4al3a", "m05l16l66l75l71l80m71l60l10l01l02l13l63l72",
        "l0am83l75l46l15l03l11l40l71l83", "m85l76l26l04l04l02l20l70l81",
        "m80l8am83l75l46l15l03l11l40l71l83", "m04l13l73l84l85l76l16l05l01l10l70l81",
        "m20l29l3al5al69m15l45", "m86m83l75l46l15l03l11l40l71l83L82L73L13L02",
        "l0am04l26l66l84l80", "m40l46l36m49l48m30l50", "m56l66L62L53L33L22",
        "l20l2al0am24l44l86m44l80", "m3al4al42l50", "l06m05l16l36l45l40m45l56l76l85l80",
        "l06m04l26l66l84l80", "m83l75l46l15l03l11l40l71l83",
        "m06L03m83l75l46l15l03l11l40l71l83", "m86m83l75l46l15l03l11l40l71l83L83L93",
        "l10l16l06m14l36l66l84", "m01l10l70l81l72l14l05l16l76l85",
        "m71l60l40l31l3al2am15l55", "m06l16l11l20l60l71l76m71l80", "m06l40l86",
        "m06l05l20l45l60l85l86", "l86m06l80", "m06l01l10l70l81m86L82L73L13L02",
        "m06l86l00l80", "m6al5al49l46l35l44l41l50l60", "m44l40l50l54l44m46l4al5al56l46",
        "m20l30l41l44l55l46l49l3al2a", "m05l16l36l54l74l85", "m02l08l88l82l02"
    };

    t_cfg        pen_cfg;
    logic [31:0] char_off = '0;
    t_pt         pts_due[$];
    logic [7:0]  chars_pending[$];

    int  errors     = 0;
    int  chars_sent = 0;
    int  pts_seen   = 0;
    int  cycles     = 0;
    int  src_pct;
    int  snk_pct;
    bit  ch_took    = 1'b0;
    bit  hold_start;
    bit  hold_used;
    int  hold_left;

    initial begin
        i_clk = 1'b0;
    end
    always #1 i_clk = ~i_clk;

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic int hexval(input byte b);
        return (b >= "a") ? b - 87 : b - 48;
    endfunction

    function automatic void push_point(input logic pen, input longint lx, input longint ly,
                                       input logic last);
        t_pt p;
        longint tx;
        longint ty;
        tx = (longint'(pen_cfg.m_xx) * lx + longint'(pen_cfg.m_xy) * ly + 8192) >>> 14;
        ty = (longint'(pen_cfg.m_yx) * lx + longint'(pen_cfg.m_yy) * ly + 8192) >>> 14;
        p.pen_down     = pen;
        p.out_x        = clamp32(longint'(pen_cfg.origin_x) + tx);
        p.out_y        = clamp32(longint'(pen_cfg.origin_y) + ty);
        p.last_of_char = last;
        pts_due.push_back(p);
    endfunction

    function automatic void plot_char(input logic [7:0] code);
        logic [6:0] c;
        int         g;
        int         n;
        string      s;
        byte        kind;
        longint     step;
        longint     base;
        longint     ly;
        logic [63:0] nxt;
        c = code[6:0];
        if (code == 8'd0) begin
            char_off = '0;
            return;
        end
        if (c >= 7'd1 && c <= 7'd5) g = c - 1;
        else if (c >= 7'd32) g = c - 27;
        else g = 36;  // control codes fall back to the question mark
        s = glyph_strokes[g];
        n = s.len() / 3;
        step = longint'(pen_cfg.grid_step);
        base = longint'({32'd0, char_off});
        push_point(1'b0, base, 0, n == 0);
        for (int i = 0; i < n; i++) begin
            kind = s[3*i];
            ly = hexval(s[3*i+2]) * step;
            if (kind == "L" || kind == "M") ly = -ly;
            push_point(kind == "l" || kind == "L", hexval(s[3*i+1]) * step + base, ly,
                       i == n - 1);
        end
        nxt = {32'd0, char_off} + 64'd10 * {44'd0, pen_cfg.grid_step};
        char_off = (nxt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nxt[31:0];
    endfunction

    // char request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            ch.valid     <= 1'b0;
            ch.char_code <= '0;
        end else if (!ch.valid || ch_took) begin
            if (chars_pending.size() > 0 && $urandom_range(99) >= src_pct) begin
                ch.valid     <= 1'b1;
                ch.char_code <= chars_pending.pop_front();
            end else begin
                ch.valid <= 1'b0;
            end
        end
    end

    // point receiver, with one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pt.ready  <= 1'b0;
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (hold_start && !hold_used && hold_left == 0) begin
            hold_used  <= 1'b1;
            hold_left  <= HoldCycles;
            pt.ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            pt.ready  <= 1'b0;
        end else begin
            pt.ready <= ($urandom_range(99) >= snk_pct);
        end
    end

    always @(posedge i_clk) begin
        ch_took <= ch.valid && ch.ready && i_rst_n;
        if (i_rst_n && ch.valid && ch.ready) begin
            plot_char(ch.char_code);
            chars_sent++;
        end
        if (i_rst_n && pt.valid && pt.ready) begin
            t_pt got;
            t_pt want;
            got.pen_down     = pt.pen_down;
            got.out_x        = pt.out_x;
            got.out_y        = pt.out_y;
            got.last_of_char = pt.last_of_char;
            pts_seen++;
            if (pts_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected point pen=%0b x=%h y=%h last=%0b", $time,
                         got.pen_down, got.out_x, got.out_y, got.last_of_char);
            end else begin
                want = pts_due.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: point mismatch exp pen=%0b x=%h y=%h last=%0b", $time,
                             want.pen_down, want.out_x, want.out_y, want.last_of_char);
                    $display("%0t:                got pen=%0b x=%h y=%h last=%0b", $time,
                             got.pen_down, got.out_x, got.out_y, got.last_of_char);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LimitCycles) begin
            $display("timeout after %0d cycles, %0d points outstanding", cycles,
                     pts_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic wait_idle();
        while (chars_pending.size() > 0 || ch.valid || pts_due.size() > 0)
            @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
        @(negedge i_clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= d;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        case (idx)
            REG_GRID_STEP: pen_cfg.grid_step = d[19:0];
            REG_M_XX:      pen_cfg.m_xx      = d[15:0];
            REG_M_XY:      pen_cfg.m_xy      = d[15:0];
            REG_M_YX:      pen_cfg.m_yx      = d[15:0];
            REG_M_YY:      pen_cfg.m_yy      = d[15:0];
            REG_ORIGIN_X:  pen_cfg.origin_x  = d;
            REG_ORIGIN_Y:  pen_cfg.origin_y  = d;
            default: ;
        endcase
        @(negedge i_clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic load_cfg(input logic [19:0] gs, input logic [15:0] xx, input logic [15:0] xy,
                            input logic [15:0] yx, input logic [15:0] yy,
                            input logic [31:0] ox, input logic [31:0] oy);
        write_reg(REG_GRID_STEP, {12'd0, gs});
        write_reg(REG_M_XX, {16'd0, xx});
        write_reg(REG_M_XY, {16'd0, xy});
        write_reg(REG_M_YX, {16'd0, yx});
        write_reg(REG_M_YY, {16'd0, yy});
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
    endtask

    task automatic load_random_cfg();
        logic [19:0] gs;
        logic [31:0] ox;
        logic [31:0] oy;
        gs = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(4096));
        ox = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(65535)) - 32'd32768;
        oy = ($urandom_range(7) == 0) ? 32'h7FFF_0000 : $urandom;
        load_cfg(gs, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), ox, oy);
    endtask

    function automatic logic [7:0] random_char();
        int r;
        logic [7:0] c;
        r = $urandom_range(99);
        if (r < 5) return 8'd0;
        if (r < 15) c = 8'($urandom_range(31, 1));
        else c = 8'($urandom_range(127, 32));
        if ($urandom_range(3) == 0) c[7] = 1'b1;
        return c;
    endfunction

    initial begin
        logic [7:0] directed [] = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd32, 8'd6, 8'd31,
                                    8'd128, 8'd134, 8'd159, 8'd65, 8'd97, 8'd95, 8'd47,
                                    8'd127, 8'd255, 8'd0, 8'd0, 8'd129, 8'd133, 8'd103,
                                    8'd48, 8'd160};
        src_pct    = 0;
        snk_pct    = 0;
        hold_start = 1'b0;
        pen_cfg    = '{grid_step: 20'd256, m_xx: 16'sd16384, m_xy: '0, m_yx: '0,
                       m_yy: 16'sd16384, origin_x: '0, origin_y: '0};
        cfg.valid  = 1'b0;
        cfg.index  = '0;
        cfg.data   = '0;
        i_rst_n    = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // default registers first, then near-extreme values in every register
        foreach (directed[i]) chars_pending.push_back(directed[i]);
        wait_idle();
        load_cfg(20'hFFFFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 32'h7FFF_FF00,
                 32'h8000_0000);
        foreach (directed[i]) chars_pending.push_back(directed[i]);
        wait_idle();

        // a run of blanks at the largest step, then an end code mid-string
        load_cfg(20'hFFFFF, 16'h0001, 16'h0000, 16'h0000, 16'h0001, 32'h0, 32'h0);
        repeat (20) chars_pending.push_back(8'd32);
        chars_pending.push_back(8'd65);
        chars_pending.push_back(8'd0);
        chars_pending.push_back(8'd65);
        wait_idle();

        for (int ph = 0; ph < 3; ph++) begin
            src_pct = (ph == 0) ? 28 : (ph == 1) ? 75 : 0;
            snk_pct = (ph == 0) ? 75 : (ph == 1) ? 28 : 0;
            for (int k = 0; k < 3; k++) begin
                load_random_cfg();
                repeat (15) chars_pending.push_back(random_char());
                if (ph == 2 && k == 0) hold_start = 1'b1;
                if (k == 1) begin
                    // sender stays quiet until every point is back
                    while (chars_pending.size() > 0 || ch.valid || pts_due.size() > 0)
                        @(posedge i_clk);
                    repeat (5) chars_pending.push_back(random_char());
                end
                wait_idle();
            end
        end

        repeat (40) @(posedge i_clk);
        $display("run covered %0d characters and %0d points", chars_sent, pts_seen);
        $display("markers, blanks, control fallback, mirrored strokes, large steps, sat");
        if (errors == 0 && pts_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d points never arrived", errors, pts_due.size());
            $display("FAILURE");
        end
        $finish;
    end
endmodule
